/* rtl/ycpp_pkg.sv */
package ycpp_pkg;

  localparam int unsigned ANGLE_BITS_DEF      = 16;
  localparam int unsigned SINE_TABLE_BITS_DEF = 10;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;
  localparam logic [31:0]     INV_SQRT2_Q16 = 32'd46341;

  // Function codes of an input word.
  localparam logic [1:0] FUNC_PROJECT = 2'd0;
  localparam logic [1:0] FUNC_TICK    = 2'd1;
  localparam logic [1:0] FUNC_PLACE   = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_FOCAL_LENGTH = 3'd0;
  localparam logic [2:0] REG_TURN_STEP    = 3'd1;
  localparam logic [2:0] REG_MOVE_SPEED   = 3'd2;
  localparam logic [2:0] REG_CENTER_X     = 3'd3;
  localparam logic [2:0] REG_CENTER_Y     = 3'd4;

  typedef enum logic [1:0] {
    OP_PROJECT = 2'd0,
    OP_TICK    = 2'd1,
    OP_PLACE   = 2'd2
  } op_t;

  typedef struct packed {
    logic key_forward;
    logic key_back;
    logic key_left;
    logic key_right;
    logic turn_left;
    logic turn_right;
  } keys_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    keys_t              keys;
    logic [15:0]        frame_time;
  } item_t;

  typedef struct packed {
    logic [30:0] focal_length;
    logic [15:0] turn_step;
    logic [30:0] move_speed;
    logic [11:0] center_x;
    logic [11:0] center_y;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] view_depth;
    logic               behind_camera;
  } res_t;

  // Sine of r quarter-steps over a quarter wave of 2^qbits steps, Q1.16.
  // Odd Taylor polynomial through x^11 in Q2.30, evaluated at elaboration.
  function automatic logic [16:0] quarter_sine(input longint unsigned r,
                                               input int unsigned qbits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    x  = (r * HALF_PI_Q30) >> qbits;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    s  = (s + 64'd8192) >> 14;
    if (s > 64'd65536) begin
      s = 64'd65536;
    end
    return s[16:0];
  endfunction

endpackage

/* rtl/ycpp_front.sv */
module ycpp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           func,
  input  logic signed [31:0]   point_x,
  input  logic signed [31:0]   point_y,
  input  logic signed [31:0]   point_z,
  input  ycpp_pkg::keys_t      keys,
  input  logic [15:0]          frame_time,
  output logic                 q_valid,
  output ycpp_pkg::item_t      q_item,
  input  logic                 q_take
);

  localparam int unsigned PTR_W = (ycpp_pkg::QUEUE_DEPTH > 1) ?
                                  $clog2(ycpp_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(ycpp_pkg::QUEUE_DEPTH + 1);

  ycpp_pkg::item_t   slots [ycpp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              accept;
  logic              keep;
  ycpp_pkg::item_t   item_in;

  assign full    = (count == CNT_W'(ycpp_pkg::QUEUE_DEPTH));
  assign accept  = push && !full;
  assign q_valid = (count != '0);
  assign q_item  = slots[rd_ptr];

  // Unused function codes are taken and dropped here.
  always_comb begin
    item_in.point_x    = point_x;
    item_in.point_y    = point_y;
    item_in.point_z    = point_z;
    item_in.keys       = keys;
    item_in.frame_time = frame_time;
    keep               = 1'b1;
    unique case (func)
      ycpp_pkg::FUNC_PROJECT: item_in.op = ycpp_pkg::OP_PROJECT;
      ycpp_pkg::FUNC_TICK:    item_in.op = ycpp_pkg::OP_TICK;
      ycpp_pkg::FUNC_PLACE:   item_in.op = ycpp_pkg::OP_PLACE;
      default: begin
        item_in.op = ycpp_pkg::OP_PROJECT;
        keep       = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      slots[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept && keep) begin
        wr_ptr <= (wr_ptr == PTR_W'(ycpp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_take && q_valid) begin
        rd_ptr <= (rd_ptr == PTR_W'(ycpp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(accept && keep) - CNT_W'(q_take && q_valid);
    end
  end

endmodule

/* rtl/ycpp_trig.sv */
module ycpp_trig #(
  parameter int unsigned ANGLE_BITS      = ycpp_pkg::ANGLE_BITS_DEF,
  parameter int unsigned SINE_TABLE_BITS = ycpp_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic [ANGLE_BITS-1:0] yaw,
  output logic signed [17:0]    sin_q16,
  output logic signed [17:0]    cos_q16
);

  localparam int unsigned QBITS   = SINE_TABLE_BITS - 2;
  localparam int unsigned QUARTER = 1 << QBITS;

  logic [16:0]                quarter_tab [QUARTER+1];
  logic [SINE_TABLE_BITS-1:0] idx_s;
  logic [SINE_TABLE_BITS-1:0] idx_c;

  for (genvar g = 0; g <= QUARTER; g++) begin : g_tab
    assign quarter_tab[g] = ycpp_pkg::quarter_sine(longint'(g), QBITS);
  end

  if (ANGLE_BITS >= SINE_TABLE_BITS) begin : g_idx_hi
    assign idx_s = yaw[ANGLE_BITS-1 -: SINE_TABLE_BITS];
  end else begin : g_idx_lo
    assign idx_s = {yaw, {(SINE_TABLE_BITS - ANGLE_BITS){1'b0}}};
  end
  assign idx_c = idx_s + SINE_TABLE_BITS'(QUARTER);

  // Full-wave sine from the quarter table by quadrant folding.
  function automatic logic signed [17:0] wave(input logic [SINE_TABLE_BITS-1:0] idx,
                                              input logic [16:0] tab [QUARTER+1]);
    logic [QBITS:0] r;
    logic [16:0]    mag;
    r = {1'b0, idx[QBITS-1:0]};
    if (idx[QBITS]) begin
      r = (QBITS+1)'(QUARTER) - r;
    end
    mag = tab[r];
    return idx[QBITS+1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  assign sin_q16 = wave(idx_s, quarter_tab);
  assign cos_q16 = wave(idx_c, quarter_tab);

endmodule

/* rtl/ycpp_back.sv */
module ycpp_back #(
  parameter int unsigned ANGLE_BITS      = ycpp_pkg::ANGLE_BITS_DEF,
  parameter int unsigned SINE_TABLE_BITS = ycpp_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  ycpp_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  ycpp_pkg::item_t q_item,
  output logic            q_take,
  output logic            out_valid,
  output ycpp_pkg::res_t  out_res,
  input  logic            pop
);

  localparam logic [40:0] QUOT_CAP = 41'd1 << 40;

  typedef enum logic [4:0] {
    ST_IDLE, ST_TRIG,
    ST_RX_A, ST_RX_B, ST_RZ_A, ST_RZ_B, ST_RZ_C,
    ST_AX_LO, ST_AX_HI, ST_AX_SUM, ST_DIV_INIT, ST_DIV, ST_AX_DONE, ST_OUT,
    ST_TK_D, ST_TK_D2, ST_TK_DG, ST_TK_DG2, ST_TK_S, ST_TK_C, ST_TK_UPD
  } state_t;

  state_t                  state;
  ycpp_pkg::op_t           op;
  logic signed [31:0]      cam_x, cam_y, cam_z;
  logic [ANGLE_BITS-1:0]   cam_yaw;
  logic signed [32:0]      rel_x, rel_y, rel_z;
  logic signed [17:0]      s, c;
  logic signed [17:0]      trig_s, trig_c;
  logic signed [65:0]      prod, acc;
  logic signed [33:0]      ma;
  logic signed [31:0]      mb;
  logic signed [65:0]      mp;
  logic signed [35:0]      rx, rz;
  logic [35:0]             mag;
  logic                    neg;
  logic                    axis;
  logic [66:0]             num;
  logic [35:0]             den;
  logic [36:0]             rem;
  logic [36:0]             rem_try;
  logic [40:0]             quot;
  logic [5:0]              cnt;
  logic signed [31:0]      scr_x, scr_y;
  logic                    behind;
  logic signed [1:0]       dz, dx;
  logic [15:0]             ftime;
  logic signed [32:0]      move_dist;
  logic signed [33:0]      ds;
  logic signed [65:0]      rnd_rx, rnd_rz, rnd_prod;
  logic signed [35:0]      rz_val;
  logic [40:0]             quot_cap;
  logic signed [43:0]      centre, axis_sum;
  logic signed [33:0]      dc_val;
  logic signed [43:0]      new_x, new_z;
  logic signed [43:0]      depth_sat;
  logic [ANGLE_BITS-1:0]   step;
  logic [ANGLE_BITS-1:0]   yaw_turned;

  ycpp_trig #(
    .ANGLE_BITS      (ANGLE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_trig (
    .yaw     (cam_yaw),
    .sin_q16 (trig_s),
    .cos_q16 (trig_c)
  );

  function automatic logic signed [43:0] sat32(input logic signed [43:0] v);
    if (v > 44'sd2147483647) begin
      return 44'sd2147483647;
    end else if (v < -44'sd2147483648) begin
      return -44'sd2147483648;
    end
    return v;
  endfunction

  function automatic logic signed [35:0] term(input logic signed [1:0]  sel,
                                              input logic signed [33:0] v);
    case (sel)
      2'sd1:   return 36'(v);
      -2'sd1:  return -36'(v);
      default: return '0;
    endcase
  endfunction

  // One shared signed multiplier; its product is always registered.
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      ST_RX_A:  begin ma = 34'(rel_x); mb = 32'(c); end
      ST_RX_B:  begin ma = 34'(rel_z); mb = 32'(s); end
      ST_RZ_A:  begin ma = 34'(rel_x); mb = 32'(s); end
      ST_RZ_B:  begin ma = 34'(rel_z); mb = 32'(c); end
      ST_AX_LO: begin ma = $signed({16'd0, mag[17:0]}); mb = $signed({1'b0, cfg.focal_length}); end
      ST_AX_HI: begin ma = $signed({16'd0, mag[35:18]}); mb = $signed({1'b0, cfg.focal_length}); end
      ST_TK_D:  begin ma = $signed({3'd0, cfg.move_speed}); mb = $signed({16'd0, ftime}); end
      ST_TK_DG: begin ma = 34'(move_dist); mb = $signed(ycpp_pkg::INV_SQRT2_Q16); end
      ST_TK_S:  begin ma = 34'(move_dist); mb = 32'(s); end
      ST_TK_C:  begin ma = 34'(move_dist); mb = 32'(c); end
      default:  begin ma = '0; mb = '0; end
    endcase
  end
  assign mp = 66'(ma) * 66'(mb);

  assign rnd_rx    = (acc - prod + 66'sd32768) >>> 16;
  assign rnd_rz    = (acc + prod + 66'sd32768) >>> 16;
  assign rnd_prod  = (prod + 66'sd32768) >>> 16;
  assign rz_val    = rnd_rz[35:0];
  assign dc_val    = rnd_prod[33:0];
  assign rem_try   = {rem[35:0], num[cnt]};
  assign quot_cap  = quot[40] ? QUOT_CAP : quot;
  assign centre    = axis ? $signed({16'd0, cfg.center_y, 16'd0})
                          : $signed({16'd0, cfg.center_x, 16'd0});
  assign axis_sum  = sat32(centre + (neg ? -$signed({3'd0, quot_cap})
                                         :  $signed({3'd0, quot_cap})));
  assign new_x     = sat32(44'(36'(cam_x) + term(dz, ds) + term(dx, dc_val)));
  assign new_z     = sat32(44'(36'(cam_z) + term(dz, dc_val) - term(dx, ds)));
  assign depth_sat = sat32(44'(rz));
  assign step      = ANGLE_BITS'(cfg.turn_step);
  assign q_take    = (state == ST_IDLE) && q_valid;

  always_comb begin
    yaw_turned = cam_yaw;
    if (q_item.keys.turn_left) begin
      yaw_turned = yaw_turned - step;
    end
    if (q_item.keys.turn_right) begin
      yaw_turned = yaw_turned + step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cam_x     <= '0;
      cam_y     <= '0;
      cam_z     <= '0;
      cam_yaw   <= '0;
      out_valid <= 1'b0;
    end else begin
      // In ST_OUT a taken word is replaced by the next one below.
      if (pop && out_valid && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            op    <= q_item.op;
            rel_x <= 33'(q_item.point_x) - 33'(cam_x);
            rel_y <= 33'(q_item.point_y) - 33'(cam_y);
            rel_z <= 33'(q_item.point_z) - 33'(cam_z);
            ftime <= q_item.frame_time;
            dz    <= q_item.keys.key_back ? -2'sd1 : (q_item.keys.key_forward ? 2'sd1 : 2'sd0);
            dx    <= q_item.keys.key_right ? 2'sd1 : (q_item.keys.key_left ? -2'sd1 : 2'sd0);
            unique case (q_item.op)
              ycpp_pkg::OP_PLACE: begin
                cam_x   <= q_item.point_x;
                cam_y   <= q_item.point_y;
                cam_z   <= q_item.point_z;
                cam_yaw <= '0;
              end
              ycpp_pkg::OP_TICK: begin
                cam_yaw <= yaw_turned;
                state   <= ST_TRIG;
              end
              default: state <= ST_TRIG;
            endcase
          end
        end
        ST_TRIG: begin
          s     <= trig_s;
          c     <= trig_c;
          state <= (op == ycpp_pkg::OP_TICK) ? ST_TK_D : ST_RX_A;
        end
        ST_RX_A: begin
          prod  <= mp;
          state <= ST_RX_B;
        end
        ST_RX_B: begin
          acc   <= prod;
          prod  <= mp;
          state <= ST_RZ_A;
        end
        ST_RZ_A: begin
          rx    <= rnd_rx[35:0];
          prod  <= mp;
          state <= ST_RZ_B;
        end
        ST_RZ_B: begin
          acc   <= prod;
          prod  <= mp;
          state <= ST_RZ_C;
        end
        ST_RZ_C: begin
          rz   <= rz_val;
          den  <= rz_val;
          axis <= 1'b0;
          neg  <= rx[35];
          mag  <= rx[35] ? 36'(-rx) : 36'(rx);
          if (rz_val <= 36'sd0) begin
            behind <= 1'b1;
            scr_x  <= '0;
            scr_y  <= '0;
            state  <= ST_OUT;
          end else begin
            behind <= 1'b0;
            state  <= ST_AX_LO;
          end
        end
        ST_AX_LO: begin
          prod  <= mp;
          state <= ST_AX_HI;
        end
        ST_AX_HI: begin
          acc   <= prod;
          prod  <= mp;
          state <= ST_AX_SUM;
        end
        ST_AX_SUM: begin
          num   <= 67'(acc[48:0]) + (67'(prod[48:0]) << 18);
          state <= ST_DIV_INIT;
        end
        ST_DIV_INIT: begin
          // A quotient of 2^41 or more lies past the cap already.
          if (36'(num[66:41]) >= den) begin
            quot  <= QUOT_CAP;
            state <= ST_AX_DONE;
          end else begin
            rem   <= 37'(num[66:41]);
            quot  <= '0;
            cnt   <= 6'd40;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (rem_try >= 37'(den)) begin
            rem  <= rem_try - 37'(den);
            quot <= {quot[39:0], 1'b1};
          end else begin
            rem  <= rem_try;
            quot <= {quot[39:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == 6'd0) begin
            state <= ST_AX_DONE;
          end
        end
        ST_AX_DONE: begin
          if (!axis) begin
            scr_x <= axis_sum[31:0];
            axis  <= 1'b1;
            neg   <= !rel_y[32];
            mag   <= rel_y[32] ? 36'(-rel_y) : 36'(rel_y);
            state <= ST_AX_LO;
          end else begin
            scr_y <= axis_sum[31:0];
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid || pop) begin
            out_valid             <= 1'b1;
            out_res.screen_x      <= scr_x;
            out_res.screen_y      <= scr_y;
            out_res.view_depth    <= depth_sat[31:0];
            out_res.behind_camera <= behind;
            state                 <= ST_IDLE;
          end
        end
        ST_TK_D: begin
          prod  <= mp;
          state <= ST_TK_D2;
        end
        ST_TK_D2: begin
          move_dist <= rnd_prod[32:0];
          state     <= (dz != 2'sd0 && dx != 2'sd0) ? ST_TK_DG : ST_TK_S;
        end
        ST_TK_DG: begin
          prod  <= mp;
          state <= ST_TK_DG2;
        end
        ST_TK_DG2: begin
          move_dist <= rnd_prod[32:0];
          state     <= ST_TK_S;
        end
        ST_TK_S: begin
          prod  <= mp;
          state <= ST_TK_C;
        end
        ST_TK_C: begin
          ds    <= rnd_prod[33:0];
          prod  <= mp;
          state <= ST_TK_UPD;
        end
        ST_TK_UPD: begin
          cam_x <= new_x[31:0];
          cam_z <= new_z[31:0];
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/yaw_camera_point_projector_unit.sv */
// Yaw camera point projector.
// Input words are pushed with push while full is low. Each word carries a
// function code: project a point, advance one frame tick (keys, turns and
// frame time), or place the camera. Only a projection yields a result word.
// Result words appear on screen_x, screen_y, view_depth and behind_camera
// while empty is low and are taken with pop. The configuration port writes
// register wr_index with wr_data on any edge where wr_en is high; it should
// only be used while the block is idle.
// The front stage accepts and decodes words into a two-entry queue; the back
// sequencer works one word at a time through a single shared multiplier and
// a bit-serial divider producing 41 quotient bits, one per cycle.
// A projection in front of the camera runs the rotation, then scaling and a
// division for each screen axis; one behind the camera ends after the rotation.
// A frame tick scales the move and updates the camera; a placement ends in idle.
// Reset clears the camera to the origin with yaw zero, restores the register
// defaults and empties the queue and the result register. When the receiver
// stalls, the finished result waits in the output register, the back stage
// stops before writing the next one, and full rises once the queue fills.
module yaw_camera_point_projector_unit #(
  parameter int unsigned ANGLE_BITS      = ycpp_pkg::ANGLE_BITS_DEF,
  parameter int unsigned SINE_TABLE_BITS = ycpp_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         func,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic               key_forward,
  input  logic               key_back,
  input  logic               key_left,
  input  logic               key_right,
  input  logic               turn_left,
  input  logic               turn_right,
  input  logic [15:0]        frame_time,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] screen_x,
  output logic signed [31:0] screen_y,
  output logic signed [31:0] view_depth,
  output logic               behind_camera,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [30:0]        wr_data
);

  ycpp_pkg::cfg_t  cfg;
  ycpp_pkg::keys_t keys;
  ycpp_pkg::item_t q_item;
  ycpp_pkg::res_t  out_res;
  logic            q_valid;
  logic            q_take;
  logic            out_valid;

  // Configuration registers; writes to indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal_length <= 31'd19660800;
      cfg.turn_step    <= 16'd182;
      cfg.move_speed   <= 31'd327680;
      cfg.center_x     <= 12'd320;
      cfg.center_y     <= 12'd240;
    end else if (wr_en) begin
      unique case (wr_index)
        ycpp_pkg::REG_FOCAL_LENGTH: cfg.focal_length <= wr_data;
        ycpp_pkg::REG_TURN_STEP:    cfg.turn_step    <= wr_data[15:0];
        ycpp_pkg::REG_MOVE_SPEED:   cfg.move_speed   <= wr_data;
        ycpp_pkg::REG_CENTER_X:     cfg.center_x     <= wr_data[11:0];
        ycpp_pkg::REG_CENTER_Y:     cfg.center_y     <= wr_data[11:0];
        default: ;
      endcase
    end
  end

  assign keys.key_forward = key_forward;
  assign keys.key_back    = key_back;
  assign keys.key_left    = key_left;
  assign keys.key_right   = key_right;
  assign keys.turn_left   = turn_left;
  assign keys.turn_right  = turn_right;

  ycpp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .func       (func),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .keys       (keys),
    .frame_time (frame_time),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_take     (q_take)
  );

  ycpp_back #(
    .ANGLE_BITS      (ANGLE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take),
    .out_valid (out_valid),
    .out_res   (out_res),
    .pop       (pop)
  );

  assign empty         = !out_valid;
  assign screen_x      = out_res.screen_x;
  assign screen_y      = out_res.screen_y;
  assign view_depth    = out_res.view_depth;
  assign behind_camera = out_res.behind_camera;

endmodule

/* bench/tb_yaw_camera_point_projector_unit.sv */
`timescale 1ns / 100ps

module tb_yaw_camera_point_projector_unit;

  // Function code that the block must ignore.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned QUARTER_STEPS = 256;
  localparam longint unsigned QUOT_CAP = 64'd1 << 40;

  // One input word as the sender sees it; func may take the unused code here.
  typedef struct packed {
    logic [1:0]         fn;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    ycpp_pkg::keys_t    keys;
    logic [15:0]        ftime;
  } word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  word_t cur = '0;
  logic wr_en = 1'b0;
  logic [2:0] wr_index = '0;
  logic [30:0] wr_data = '0;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic signed [31:0] view_depth;
  logic behind_camera;

  always #5 clk = ~clk;

  yaw_camera_point_projector_unit i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .func(cur.fn), .point_x(cur.px), .point_y(cur.py), .point_z(cur.pz),
    .key_forward(cur.keys.key_forward), .key_back(cur.keys.key_back),
    .key_left(cur.keys.key_left), .key_right(cur.keys.key_right),
    .turn_left(cur.keys.turn_left), .turn_right(cur.keys.turn_right),
    .frame_time(cur.ftime), .empty(empty), .pop(pop),
    .screen_x(screen_x), .screen_y(screen_y), .view_depth(view_depth),
    .behind_camera(behind_camera), .wr_en(wr_en), .wr_index(wr_index),
    .wr_data(wr_data)
  );

  // Shadow copy of the camera state and the registers, kept by the predictor.
  ycpp_pkg::cfg_t shadow_cfg;
  longint cam_px, cam_py, cam_pz;
  logic [15:0] cam_heading;

  // Projections that have been accepted and whose result word is still due.
  ycpp_pkg::res_t pending_proj[$];
  int unsigned fail_count = 0;

  // Sender burst state and receiver stall state.
  int unsigned burst_left = 0;
  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;
  int unsigned hold_left = 0;
  logic [15:0] pop_pattern = 16'hFFFF;
  int unsigned rx_cycle = 0;

  function automatic longint rnd16(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Sine over a quarter wave, Q16.16, from the odd Taylor series in Q2.30.
  function automatic longint quarter_wave(int unsigned r);
    longint unsigned x, x2, t, s;
    x  = longint'(r) * ycpp_pkg::HALF_PI_Q30 / QUARTER_STEPS;
    x2 = (x * x) >> 30;
    t  = ycpp_pkg::ONE_Q30;
    t  = ycpp_pkg::ONE_Q30 - ((x2 * t) >> 30) / 110;
    t  = ycpp_pkg::ONE_Q30 - ((x2 * t) >> 30) / 72;
    t  = ycpp_pkg::ONE_Q30 - ((x2 * t) >> 30) / 42;
    t  = ycpp_pkg::ONE_Q30 - ((x2 * t) >> 30) / 20;
    t  = ycpp_pkg::ONE_Q30 - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    s  = (s + 8192) >> 14;
    if (s > 65536) s = 65536;
    return longint'(s);
  endfunction

  function automatic longint wave_at(logic [9:0] idx);
    int unsigned r;
    r = idx[7:0];
    case (idx[9:8])
      2'd0: return quarter_wave(r);
      2'd1: return quarter_wave(QUARTER_STEPS - r);
      2'd2: return -quarter_wave(r);
      default: return -quarter_wave(QUARTER_STEPS - r);
    endcase
  endfunction

  task automatic heading_trig(output longint s, output longint c);
    logic [9:0] idx;
    idx = cam_heading[15:6];
    s = wave_at(idx);
    c = wave_at(idx + 10'd256);
  endtask

  // Truncated |num| * focal / den, capped at 2^40, then signed and centered.
  function automatic longint screen_axis(longint centre, longint num, longint den,
                                         bit minus);
    logic [127:0] prod, quo;
    longint unsigned mag;
    longint q;
    mag  = num < 0 ? longint'(-num) : longint'(num);
    prod = 128'(mag) * 128'(shadow_cfg.focal_length);
    quo  = prod / 128'(den);
    if (quo > 128'(QUOT_CAP)) quo = 128'(QUOT_CAP);
    q = longint'(quo[63:0]);
    if ((num < 0) != minus) q = -q;
    return clamp32(centre + q);
  endfunction

  // Advance the shadow state by one accepted word; a projection queues its result.
  task automatic predict_word(input word_t w);
    longint s, c, rel_x, rel_y, rel_z, rx, rz, d, ds, dc, dx, dz;
    ycpp_pkg::res_t r;
    case (w.fn)
      ycpp_pkg::FUNC_PROJECT: begin
        rel_x = longint'(w.px) - cam_px;
        rel_y = longint'(w.py) - cam_py;
        rel_z = longint'(w.pz) - cam_pz;
        heading_trig(s, c);
        rx = rnd16(rel_x * c - rel_z * s);
        rz = rnd16(rel_x * s + rel_z * c);
        r = '0;
        r.behind_camera = (rz <= 0);
        if (!r.behind_camera) begin
          r.screen_x = 32'(screen_axis(longint'(shadow_cfg.center_x) <<< 16, rx, rz, 1'b0));
          r.screen_y = 32'(screen_axis(longint'(shadow_cfg.center_y) <<< 16, rel_y, rz,
                                       1'b1));
        end
        r.view_depth = 32'(clamp32(rz));
        pending_proj.push_back(r);
      end
      ycpp_pkg::FUNC_TICK: begin
        dz = 0;
        dx = 0;
        if (w.keys.key_forward) dz = 1;
        if (w.keys.key_back) dz = -1;
        if (w.keys.key_left) dx = -1;
        if (w.keys.key_right) dx = 1;
        if (w.keys.turn_left) cam_heading = cam_heading - shadow_cfg.turn_step;
        if (w.keys.turn_right) cam_heading = cam_heading + shadow_cfg.turn_step;
        d = rnd16(longint'(shadow_cfg.move_speed) * longint'(w.ftime));
        if (dx != 0 && dz != 0) d = rnd16(d * longint'(ycpp_pkg::INV_SQRT2_Q16));
        heading_trig(s, c);
        ds = rnd16(d * s);
        dc = rnd16(d * c);
        cam_px = clamp32(cam_px + dz * ds + dx * dc);
        cam_pz = clamp32(cam_pz + dz * dc - dx * ds);
      end
      ycpp_pkg::FUNC_PLACE: begin
        cam_px = longint'(w.px);
        cam_py = longint'(w.py);
        cam_pz = longint'(w.pz);
        cam_heading = '0;
      end
      default: ;
    endcase
  endtask

  // Offer one word and hold it until the block takes it, then maybe pause.
  task automatic send_word(input word_t w);
    int unsigned gap;
    @(negedge clk);
    cur <= w;
    push <= 1'b1;
    do @(posedge clk); while (full);
    predict_word(w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        @(negedge clk);
        push <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic stop_sending();
    @(negedge clk);
    push <= 1'b0;
  endtask

  // Registers change only once nothing is in flight; ticks and placements
  // give no result, so a margin beyond the last projection is allowed.
  task automatic write_reg(input logic [2:0] idx, input logic [30:0] value);
    stop_sending();
    wait (pending_proj.size() == 0);
    repeat (150) @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= value;
    case (idx)
      ycpp_pkg::REG_FOCAL_LENGTH: shadow_cfg.focal_length = value;
      ycpp_pkg::REG_TURN_STEP:    shadow_cfg.turn_step = value[15:0];
      ycpp_pkg::REG_MOVE_SPEED:   shadow_cfg.move_speed = value;
      ycpp_pkg::REG_CENTER_X:     shadow_cfg.center_x = value[11:0];
      ycpp_pkg::REG_CENTER_Y:     shadow_cfg.center_y = value[11:0];
      default: ;
    endcase
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic write_all(input logic [30:0] f, input logic [15:0] t, input logic [30:0] m,
                           input logic [11:0] x, input logic [11:0] y);
    write_reg(ycpp_pkg::REG_FOCAL_LENGTH, f);
    write_reg(ycpp_pkg::REG_TURN_STEP, 31'(t));
    write_reg(ycpp_pkg::REG_MOVE_SPEED, m);
    write_reg(ycpp_pkg::REG_CENTER_X, 31'(x));
    write_reg(ycpp_pkg::REG_CENTER_Y, 31'(y));
  endtask

  // Coordinates mostly near the origin so that points land in front of and
  // behind the camera about equally, with full range values mixed in.
  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      3: return $signed($urandom_range(0, 32'h7FF)) - 32'sd1024;
      default: return $signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000;
    endcase
  endfunction

  function automatic word_t pick_word();
    word_t w;
    int unsigned k;
    w.px = pick_coord();
    w.py = pick_coord();
    w.pz = pick_coord();
    w.keys = ycpp_pkg::keys_t'($urandom);
    w.ftime = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2200));
    k = $urandom_range(0, 99);
    if (k < 58) w.fn = ycpp_pkg::FUNC_PROJECT;
    else if (k < 86) w.fn = ycpp_pkg::FUNC_TICK;
    else if (k < 97) w.fn = ycpp_pkg::FUNC_PLACE;
    else w.fn = FUNC_UNUSED;
    return w;
  endfunction

  function automatic word_t mk(logic [1:0] fn, logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z, ycpp_pkg::keys_t k, logic [15:0] ft);
    word_t w;
    w.fn = fn;
    w.px = x;
    w.py = y;
    w.pz = z;
    w.keys = k;
    w.ftime = ft;
    return w;
  endfunction

  // Receiver: pop follows a stall pattern that changes now and then, with
  // stretches of no stalls, and a long hold-off when a test asks for one.
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_req) begin
      hold_left = 400;
      hold_req = 1'b0;
    end
    if (rx_cycle % 64 == 0) begin
      pop_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom) | 16'h0001;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= pop_pattern[rx_cycle % 16];
    end
  end

  // Every result word taken is compared with the oldest projection due.
  always @(posedge clk) begin
    ycpp_pkg::res_t exp_r;
    if (!rst && pop && !empty) begin
      if (pending_proj.size() == 0) begin
        $error("result word with no projection due: %0d %0d %0d %0b",
               screen_x, screen_y, view_depth, behind_camera);
        fail_count++;
      end else begin
        exp_r = pending_proj.pop_front();
        if (screen_x !== exp_r.screen_x) begin
          $error("screen_x expected %0d actual %0d", exp_r.screen_x, screen_x);
          fail_count++;
        end
        if (screen_y !== exp_r.screen_y) begin
          $error("screen_y expected %0d actual %0d", exp_r.screen_y, screen_y);
          fail_count++;
        end
        if (view_depth !== exp_r.view_depth) begin
          $error("view_depth expected %0d actual %0d", exp_r.view_depth, view_depth);
          fail_count++;
        end
        if (behind_camera !== exp_r.behind_camera) begin
          $error("behind_camera expected %0b actual %0b", exp_r.behind_camera,
                 behind_camera);
          fail_count++;
        end
      end
    end
  end

  // Directed words: points in front, behind and exactly on the camera plane,
  // coordinate extremes, single, opposing and diagonal keys, yaw wrap, full
  // frame time, placement at the extremes and the ignored function code.
  task automatic test_directed();
    ycpp_pkg::keys_t none, k;
    none = '0;
    send_word(mk(ycpp_pkg::FUNC_PROJECT, 32'sh00010000, 32'sh00020000, 32'sh000A0000,
                 none, 16'd0));
    send_word(mk(ycpp_pkg::FUNC_PROJECT, 32'sh00010000, -32'sh00020000, -32'sh000A0000,
                 none, 16'd0));
    send_word(mk(ycpp_pkg::FUNC_PROJECT, 32'sh00050000, 32'sh00010000, 32'sh0, none, 16'd0));
    send_word(mk(ycpp_pkg::FUNC_PROJECT, 32'sh7FFFFFFF, 32'sh80000000, 32'sh00000001,
                 none, 16'd0));
    send_word(mk(ycpp_pkg::FUNC_PROJECT, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                 none, 16'd0));
    k = '0; k.key_forward = 1'b1;
    send_word(mk(ycpp_pkg::FUNC_TICK, 0, 0, 0, k, 16'hFFFF));
    k = '0; k.key_forward = 1'b1; k.key_back = 1'b1; k.key_left = 1'b1; k.key_right = 1'b1;
    send_word(mk(ycpp_pkg::FUNC_TICK, 0, 0, 0, k, 16'h8000));
    k = '0; k.key_left = 1'b1; k.key_back = 1'b1; k.turn_left = 1'b1;
    send_word(mk(ycpp_pkg::FUNC_TICK, 0, 0, 0, k, 16'h1000));
    send_word(mk(ycpp_pkg::FUNC_PROJECT, 32'sh00030000, 32'sh0, 32'sh00140000, none, 16'd0));
    k = '0; k.turn_right = 1'b1; k.key_right = 1'b1;
    send_word(mk(ycpp_pkg::FUNC_TICK, 0, 0, 0, k, 16'h0444));
    k = '0; k.turn_left = 1'b1; k.turn_right = 1'b1;
    send_word(mk(ycpp_pkg::FUNC_TICK, 0, 0, 0, k, 16'h0));
    send_word(mk(ycpp_pkg::FUNC_PROJECT, -32'sh00030000, 32'sh00010000, 32'sh00140000,
                 none, 16'd0));
    send_word(mk(ycpp_pkg::FUNC_PLACE, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                 none, 16'd0));
    send_word(mk(ycpp_pkg::FUNC_PROJECT, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                 none, 16'd0));
    k = '0; k.key_back = 1'b1;
    send_word(mk(ycpp_pkg::FUNC_TICK, 0, 0, 0, k, 16'hFFFF));
    send_word(mk(ycpp_pkg::FUNC_PLACE, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                 none, 16'd0));
    send_word(mk(ycpp_pkg::FUNC_PROJECT, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                 none, 16'd0));
    send_word(mk(FUNC_UNUSED, 32'sh12345678, -32'sh1, 32'sh7FFFFFFF,
                 ycpp_pkg::keys_t'('1), 16'hFFFF));
    send_word(mk(ycpp_pkg::FUNC_PLACE, 0, 0, 0, none, 16'd0));
    send_word(mk(ycpp_pkg::FUNC_PROJECT, 32'sh0, 32'sh0, 32'sh00000001, none, 16'd0));
    send_word(mk(ycpp_pkg::FUNC_PROJECT, 32'sh0, 32'sh0, -32'sh00000001, none, 16'd0));
  endtask

  task automatic test_random(input int unsigned count);
    repeat (count) send_word(pick_word());
  endtask

  // The receiver holds off for a long stretch while projections keep coming,
  // so the queue fills and full has to stall the sender.
  task automatic test_backpressure();
    word_t w;
    stop_sending();
    wait (pending_proj.size() == 0);
    @(posedge clk);
    hold_req = 1'b1;
    gaps_on = 1'b0;
    repeat (12) begin
      w = pick_word();
      w.fn = ycpp_pkg::FUNC_PROJECT;
      send_word(w);
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    shadow_cfg.focal_length = 31'd19660800;
    shadow_cfg.turn_step = 16'd182;
    shadow_cfg.move_speed = 31'd327680;
    shadow_cfg.center_x = 12'd320;
    shadow_cfg.center_y = 12'd240;
    cam_px = 0;
    cam_py = 0;
    cam_pz = 0;
    cam_heading = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random(400);
    write_all(31'h7FFFFFFF, 16'hFFFF, 31'h7FFFFFFF, 12'hFFF, 12'hFFF);
    test_directed();
    test_random(200);
    write_all(31'h0, 16'h0, 31'h0, 12'h0, 12'h0);
    test_random(100);
    write_all(31'($urandom), 16'($urandom), 31'($urandom_range(0, 32'h7FFFF)),
              12'($urandom), 12'($urandom));
    test_random(250);
    write_all(31'd19660800, 16'd4096, 31'd327680, 12'd320, 12'd240);
    test_random(250);
    test_backpressure();

    stop_sending();
    wait (pending_proj.size() == 0);
    repeat (200) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

endmodule
